FILE: rtl/vmam_pkg.sv
// Package for the video memory address map: sizes, codes, beat payload types
// and the address-to-storage index function. No dependencies.
`default_nettype none

package vmam_pkg;

	localparam int PATTERN_BYTES = 8192;
	localparam int TABLE_BYTES   = 1024;
	localparam int PALETTE_BYTES = 32;

	// One flat storage array: pattern bytes, then both name tables, then palette
	localparam int MEM_DEPTH = PATTERN_BYTES + 2 * TABLE_BYTES + PALETTE_BYTES;
	localparam int IDX_W     = $clog2(MEM_DEPTH);

	localparam int ADDR_W = 14;
	localparam int DATA_W = 8;

	localparam logic [IDX_W-1:0] NT_BASE  = IDX_W'(PATTERN_BYTES);
	localparam logic [IDX_W-1:0] PAL_BASE = IDX_W'(PATTERN_BYTES + 2 * TABLE_BYTES);

	localparam logic [5:0]        PAL_PAGE  = 6'h3F;
	localparam logic [DATA_W-1:0] GRAY_MASK = 8'h30;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic MIRROR_HORZ = 1'b0;

	// Configuration register indexes
	localparam int   CFG_IDX_W  = 1;
	localparam logic REG_MIRROR = 1'b0;
	localparam logic REG_GRAY   = 1'b1;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
	} rsp_t;

	// Flow-control signals from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic clearing;
		logic s1_move;
	} ctrl_t;

	function automatic logic is_palette(input logic [ADDR_W-1:0] a);
		return a[13:8] == PAL_PAGE;
	endfunction

	function automatic logic [IDX_W-1:0] map_index(input logic [ADDR_W-1:0] a,
			input logic mirror);
		logic       tsel;
		logic [4:0] p;
		tsel = (mirror == MIRROR_HORZ) ? a[11] : a[10];
		p    = a[4:0];
		// palette entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
		if (a[4] && (a[1:0] == 2'b00)) begin
			p[4] = 1'b0;
		end
		if (!a[13]) begin
			return {1'b0, a[12:0]};
		end else if (!is_palette(a)) begin
			return NT_BASE + {3'b000, tsel, a[9:0]};
		end else begin
			return PAL_BASE + {9'b0, p};
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/vmam_stream_if.sv
// Valid/ready channel carrying one payload per beat.
// Payload type is set per instance, normally from vmam_pkg.
`default_nettype none

interface vmam_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/vmam_ram.sv
// Single-port synchronous byte store, registered read data.
// Uses vmam_pkg for default sizes only.
`default_nettype none

module vmam_ram #(
	parameter int DEPTH  = vmam_pkg::MEM_DEPTH,
	parameter int DATA_W = vmam_pkg::DATA_W
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/vmam_ctrl.sv
// Flow control for the address map: post-reset clearing sweep, read stage
// and output register occupancy. Uses vmam_pkg::ctrl_t.
`default_nettype none

module vmam_ctrl #(
	parameter int DEPTH = vmam_pkg::MEM_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [$clog2(DEPTH)-1:0]    clr_idx,
	output vmam_pkg::ctrl_t                  ctrl
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CLR_END = CNT_W'(DEPTH);

	logic [CNT_W-1:0] clr_q;
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             clearing;
	logic             s1_move;
	logic             accept;

	assign clearing = clr_q != CLR_END;
	assign s1_move  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !clearing && (!s1_valid_q || s1_move);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign clr_idx       = clr_q[IDX_W-1:0];
	assign out_valid     = out_valid_q;
	assign ctrl.accept   = accept;
	assign ctrl.clearing = clearing;
	assign ctrl.s1_move  = s1_move;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !clearing)
		else $error("beat accepted during clearing sweep");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted beat lost before read stage");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while read stage is stalled");

	a_clear_steps: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> (clr_q == $past(clr_q) + 1'b1))
		else $error("clearing sweep skipped an entry");

endmodule

`default_nettype wire

FILE: rtl/video_memory_address_map.sv
// Top level of the video memory address map: config registers, address
// decode, flat byte store and response register. Needs vmam_pkg,
// vmam_stream_if, vmam_ram and vmam_ctrl.
//
//   channel  dir  beat contents                      accepted when
//   -------  ---  ---------------------------------  -----------------------
//   req      in   command, address[13:0], write_data req.valid & req.ready
//   rsp      out  read_data                          rsp.valid & rsp.ready
//   cfg      in   cfg_index, cfg_data                cfg_we
//
// One request per cycle sustained while rsp is taken; a response is
// presented after the memory read register and the response register.
// After reset a clearing sweep zeroes all 10272 bytes, one a cycle
// (pattern, both name tables, palette), with req.ready low.
// A stalled response holds one more request in the read stage; further
// requests wait until rsp is taken.
`default_nettype none

module video_memory_address_map (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [vmam_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic                                   cfg_data,
	vmam_stream_if.sink                                 req,
	vmam_stream_if.source                               rsp
);

	// config registers
	logic mirror_q;
	logic gray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			gray_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				vmam_pkg::REG_MIRROR: mirror_q <= cfg_data;
				vmam_pkg::REG_GRAY:   gray_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	vmam_pkg::ctrl_t                ctrl;
	logic [vmam_pkg::IDX_W-1:0]     clr_idx;
	logic                           out_valid;

	vmam_ctrl #(
		.DEPTH(vmam_pkg::MEM_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.clr_idx   (clr_idx),
		.ctrl      (ctrl)
	);

	// decode: flat index, palette flag, grayscale on palette writes
	logic [vmam_pkg::IDX_W-1:0]  req_idx;
	logic                        req_pal;
	logic                        req_wr;
	logic [vmam_pkg::DATA_W-1:0] req_wdata;

	assign req_idx   = vmam_pkg::map_index(req.payload.address, mirror_q);
	assign req_pal   = vmam_pkg::is_palette(req.payload.address);
	assign req_wr    = req.payload.command == vmam_pkg::CMD_WRITE;
	assign req_wdata = (req_pal && gray_q) ?
		(req.payload.write_data & vmam_pkg::GRAY_MASK) : req.payload.write_data;

	// store port: the sweep owns it while clearing
	logic                        mem_en;
	logic                        mem_we;
	logic [vmam_pkg::IDX_W-1:0]  mem_addr;
	logic [vmam_pkg::DATA_W-1:0] mem_wdata;
	logic [vmam_pkg::DATA_W-1:0] mem_rdata;

	assign mem_en    = ctrl.clearing || ctrl.accept;
	assign mem_we    = ctrl.clearing || req_wr;
	assign mem_addr  = ctrl.clearing ? clr_idx : req_idx;
	assign mem_wdata = ctrl.clearing ? '0 : req_wdata;

	vmam_ram #(
		.DEPTH (vmam_pkg::MEM_DEPTH),
		.DATA_W(vmam_pkg::DATA_W)
	) u_ram (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// read stage side info
	logic wr_s1;
	logic pal_s1;

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			wr_s1  <= req_wr;
			pal_s1 <= req_pal;
		end
	end

	// response register: writes answer zero, palette reads see grayscale
	logic [vmam_pkg::DATA_W-1:0] rsp_data_q;

	always_ff @(posedge clk) begin
		if (ctrl.s1_move) begin
			if (wr_s1) begin
				rsp_data_q <= '0;
			end else if (pal_s1 && gray_q) begin
				rsp_data_q <= mem_rdata & vmam_pkg::GRAY_MASK;
			end else begin
				rsp_data_q <= mem_rdata;
			end
		end
	end

	assign rsp.valid             = out_valid;
	assign rsp.payload.read_data = rsp_data_q;

endmodule

`default_nettype wire
